>>> rtl/rhec_pkg.sv
`timescale 1ns / 1ps
// Package for the rich header extract and checksum block.
// Holds the sequencer states, result and control types, and fixed constants.
package rhec_pkg;

    localparam int POS_W     = 10;
    localparam int OFF_W     = 9;
    localparam int CMP_W     = 10;
    localparam int M_TDATA_W = 136;

    localparam logic [31:0] MARK_RICH   = 32'h6863_6952;
    localparam logic [31:0] MARK_DANS   = 32'h536E_6144;
    localparam logic [OFF_W-1:0] SKIP_LO    = 9'h03C;
    localparam logic [OFF_W-1:0] SKIP_HI    = 9'h040;
    localparam logic [OFF_W-1:0] SCAN_NEXT  = 9'd68;
    localparam logic [OFF_W-1:0] PE_MIN     = 9'd72;
    localparam logic [5:0]       MAX_ENTRIES = 6'd53;

    localparam logic [1:0] STAT_NONE    = 2'd0;
    localparam logic [1:0] STAT_NO_DANS = 2'd1;
    localparam logic [1:0] STAT_FOUND   = 2'd2;
    localparam logic [1:0] STAT_SHORT   = 2'd3;

    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_RICH_CHK,
        ST_KEY_CHK,
        ST_DANS_CHK,
        ST_SUM,
        ST_ENT_TEST,
        ST_ENT_USE,
        ST_ENT_EMIT,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic        load;
        logic        add;
        logic [31:0] load_val;
        logic [31:0] operand;
        logic [4:0]  amt;
    } ra_ctrl_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] prod_code;
        logic [15:0] build_code;
        logic [31:0] use_total;
        logic [1:0]  status;
        logic [31:0] xor_key;
        logic [31:0] checksum;
        logic [5:0]  entry_count;
        logic        final_res;
    } res_t;

endpackage

>>> rtl/rhec_store.sv
`timescale 1ns / 1ps
// Byte store of the file prefix: one write port and one registered read port.
// Depends on nothing but its parameter.
module rhec_store #(
    parameter int STORE_BYTES = 512
) (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [$clog2(STORE_BYTES)-1:0] wr_addr,
    input  logic [7:0]                     wr_data,
    input  logic [$clog2(STORE_BYTES)-1:0] rd_addr,
    output logic [7:0]                     rd_data
);

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/rhec_rotadd.sv
`timescale 1ns / 1ps
// Shared rotate-left-and-add unit that holds the checksum accumulator.
// Depends on rhec_pkg for its control struct.
module rhec_rotadd
    import rhec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  ra_ctrl_t    ctrl,
    output logic [31:0] acc
);

    logic [31:0] acc_reg, acc_next;
    logic [63:0] rot_wide;

    always_comb begin
        rot_wide = {ctrl.operand, ctrl.operand} << ctrl.amt;
        acc_next = acc_reg;
        if (ctrl.load) begin
            acc_next = ctrl.load_val;
        end else if (ctrl.add) begin
            acc_next = acc_reg + rot_wide[63:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

>>> rtl/rhec_seq.sv
`timescale 1ns / 1ps
// Sequencer: loads bytes, scans for the marks, walks the checksum and entries.
// Depends on rhec_pkg; drives rhec_store and rhec_rotadd.
module rhec_seq
    import rhec_pkg::*;
#(
    parameter int STORE_BYTES = 512
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic [7:0]                     s_data,
    input  logic                           s_last,
    output logic                           s_ready,
    input  logic [OFF_W-1:0]               pe_base,
    output logic                           mem_we,
    output logic [$clog2(STORE_BYTES)-1:0] mem_waddr,
    output logic [7:0]                     mem_wdata,
    output logic [$clog2(STORE_BYTES)-1:0] mem_raddr,
    input  logic [7:0]                     mem_rdata,
    input  logic [31:0]                    acc,
    output ra_ctrl_t                       ra,
    input  logic                           slot_free,
    output logic                           push,
    output res_t                           res
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam int CW = $clog2(STORE_BYTES + 1);

    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    logic [CW-1:0]     rcv_reg, rcv_next, rcv_inc;
    logic [POS_W-1:0]  pos_reg, pos_next, fetch_addr;
    logic [2:0]        fcnt_reg, fcnt_next;
    logic [31:0]       word_reg, word_next;
    logic [OFF_W-1:0]  rich_reg, rich_next;
    logic [OFF_W-1:0]  dans_reg, dans_next;
    logic [31:0]       key_reg, key_next;
    logic [31:0]       comp_reg, comp_next;
    logic [1:0]        status_reg, status_next;
    logic [5:0]        n_reg, n_next;
    logic              pend_reg, pend_next;
    logic [OFF_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              accept;
    logic              store_room;
    logic [31:0]       use_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            rcv_reg      <= '0;
            fcnt_reg     <= '0;
            pend_reg     <= 1'b0;
            n_reg        <= '0;
            status_reg   <= STAT_NONE;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            rcv_reg      <= rcv_next;
            fcnt_reg     <= fcnt_next;
            pend_reg     <= pend_next;
            n_reg        <= n_next;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        word_reg     <= word_next;
        rich_reg     <= rich_next;
        dans_reg     <= dans_next;
        key_reg      <= key_next;
        comp_reg     <= comp_next;
        pend_idx_reg <= pend_idx_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign store_room = (rcv_reg < CW'(STORE_BYTES));
    assign rcv_inc    = store_room ? rcv_reg + 1'b1 : rcv_reg;
    assign mem_we     = accept && store_room;
    assign mem_waddr  = rcv_reg[AW-1:0];
    assign mem_wdata  = s_data;
    assign fetch_addr = pos_reg + POS_W'(fcnt_reg[1:0]);
    assign use_val    = word_reg ^ key_reg;

    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        rcv_next      = rcv_reg;
        pos_next      = pos_reg;
        fcnt_next     = fcnt_reg;
        word_next     = word_reg;
        rich_next     = rich_reg;
        dans_next     = dans_reg;
        key_next      = key_reg;
        comp_next     = comp_reg;
        status_next   = status_reg;
        n_next        = n_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        mem_raddr     = pos_reg[AW-1:0];
        push          = 1'b0;
        res           = '0;
        ra            = '0;

        // The byte pass feeds the rotate-add unit in the cycle after each read, skipping offsets 0x3C to 0x3F.
        if (pend_reg && !(pend_idx_reg >= SKIP_LO && pend_idx_reg < SKIP_HI)) begin
            ra.add     = 1'b1;
            ra.operand = {24'd0, mem_rdata};
            ra.amt     = pend_idx_reg[4:0];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    rcv_next = rcv_inc;
                    if (s_last) begin
                        rcv_next = '0;
                        key_next = '0;
                        n_next   = '0;
                        if (pe_base < PE_MIN) begin
                            status_next = STAT_NONE;
                            state_next  = ST_SUMMARY;
                        end else if (CMP_W'(rcv_inc) < CMP_W'(pe_base) + CMP_W'(4)) begin
                            status_next = STAT_SHORT;
                            state_next  = ST_SUMMARY;
                        end else begin
                            status_next = STAT_NONE;
                            pos_next    = POS_W'(pe_base) - POS_W'(4);
                            ret_next    = ST_RICH_CHK;
                            fcnt_next   = '0;
                            state_next  = ST_FETCH;
                        end
                    end
                end
            end
            ST_FETCH: begin
                mem_raddr = fetch_addr[AW-1:0];
                fcnt_next = fcnt_reg + 1'b1;
                if (fcnt_reg != 3'd0) begin
                    word_next = {mem_rdata, word_reg[31:8]};
                end
                if (fcnt_reg == 3'd4) begin
                    fcnt_next  = '0;
                    state_next = ret_reg;
                end
            end
            ST_RICH_CHK: begin
                if (word_reg == MARK_RICH) begin
                    rich_next  = pos_reg[OFF_W-1:0];
                    pos_next   = pos_reg + POS_W'(4);
                    ret_next   = ST_KEY_CHK;
                    state_next = ST_FETCH;
                end else if (pos_reg >= POS_W'(SCAN_NEXT)) begin
                    pos_next   = pos_reg - POS_W'(4);
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_SUMMARY;
                end
            end
            ST_KEY_CHK: begin
                key_next    = word_reg;
                status_next = STAT_NO_DANS;
                if (rich_reg >= SCAN_NEXT) begin
                    pos_next   = POS_W'(rich_reg) - POS_W'(4);
                    ret_next   = ST_DANS_CHK;
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_SUMMARY;
                end
            end
            ST_DANS_CHK: begin
                if ((word_reg ^ key_reg) == MARK_DANS) begin
                    dans_next   = pos_reg[OFF_W-1:0];
                    status_next = STAT_FOUND;
                    ra.load     = 1'b1;
                    ra.load_val = 32'(pos_reg);
                    pos_next    = '0;
                    state_next  = ST_SUM;
                end else if (pos_reg >= POS_W'(SCAN_NEXT)) begin
                    pos_next   = pos_reg - POS_W'(4);
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_SUMMARY;
                end
            end
            ST_SUM: begin
                if (pos_reg < POS_W'(dans_reg)) begin
                    mem_raddr     = pos_reg[AW-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = pos_reg[OFF_W-1:0];
                    pos_next      = pos_reg + 1'b1;
                end else begin
                    pos_next   = POS_W'(dans_reg) + POS_W'(16);
                    state_next = ST_ENT_TEST;
                end
            end
            ST_ENT_TEST: begin
                if (CMP_W'(pos_reg) + CMP_W'(8) <= CMP_W'(rich_reg) && n_reg < MAX_ENTRIES) begin
                    ret_next   = ST_ENT_USE;
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_SUMMARY;
                end
            end
            ST_ENT_USE: begin
                comp_next  = word_reg ^ key_reg;
                pos_next   = pos_reg + POS_W'(4);
                ret_next   = ST_ENT_EMIT;
                state_next = ST_FETCH;
            end
            ST_ENT_EMIT: begin
                res.kind       = KIND_ENTRY;
                res.prod_code  = comp_reg[31:16];
                res.build_code = comp_reg[15:0];
                res.use_total  = use_val;
                if (slot_free) begin
                    push       = 1'b1;
                    ra.add     = 1'b1;
                    ra.operand = comp_reg;
                    ra.amt     = use_val[4:0];
                    n_next     = n_reg + 1'b1;
                    pos_next   = pos_reg + POS_W'(4);
                    state_next = ST_ENT_TEST;
                end
            end
            ST_SUMMARY: begin
                res.kind        = KIND_SUMMARY;
                res.status      = status_reg;
                res.xor_key     = key_reg;
                res.checksum    = (status_reg == STAT_FOUND) ? acc : 32'd0;
                res.entry_count = n_reg;
                res.final_res   = 1'b1;
                if (slot_free) begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/rich_header_extract_checksum.sv
`timescale 1ns / 1ps
// Rich header extractor: bytes load one per cycle into the byte store; after the item marked
// last the block is busy with analysis, then emits one result per entry and a summary item.
// Every word is read byte by byte through the store's single read port, the checksum byte
// pass reads each byte below the DanS mark, and each entry waits for the result side to be
// ready. Depends on rhec_pkg, rhec_store, rhec_rotadd and rhec_seq.
module rich_header_extract_checksum
    import rhec_pkg::*;
#(
    parameter int STORE_BYTES = 512
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [OFF_W-1:0]     cfg_wr_data,   // PE signature offset
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,       // data_byte
    input  logic                 s_tlast,       // last
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // prod_code, build_code, use_total, status, xor_key, checksum, entry_count
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,       // kind
    output logic                 m_tlast        // final_res
);

    localparam int AW = $clog2(STORE_BYTES);

    logic [OFF_W-1:0] pe_base_reg;
    logic             m_valid_reg, m_valid_next;
    res_t             res_reg;
    res_t             res;
    ra_ctrl_t         ra;
    logic [31:0]      acc;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [7:0]       mem_wdata, mem_rdata;
    logic             slot_free, push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pe_base_reg <= '0;
        end else if (cfg_wr_en) begin
            pe_base_reg <= cfg_wr_data;
        end
    end

    rhec_store #(.STORE_BYTES(STORE_BYTES)) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    rhec_rotadd u_rotadd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ra),
        .acc     (acc)
    );

    rhec_seq #(.STORE_BYTES(STORE_BYTES)) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_data    (s_tdata),
        .s_last    (s_tlast),
        .s_ready   (s_tready),
        .pe_base   (pe_base_reg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .acc       (acc),
        .ra        (ra),
        .slot_free (slot_free),
        .push      (push),
        .res       (res)
    );

    assign slot_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.final_res;
    assign m_tdata  = {res_reg.entry_count, res_reg.checksum, res_reg.xor_key,
                       res_reg.status, res_reg.use_total, res_reg.build_code,
                       res_reg.prod_code};

endmodule

>>> rtl/rhec_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the rich header extractor, bound to its top level.
// Depends on rhec_pkg for the result bus width.
module rhec_port_checks
    import rhec_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result item changed.");

    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("Input accepted while analysis runs.");

    a_entry_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tlast && m_tdata[135:64] == '0)
        else $error("Entry item carries summary fields.");

    a_summary_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser && m_tdata[65:64] != STAT_FOUND
        |-> m_tlast && m_tdata[135:98] == '0 && m_tdata[63:0] == '0)
        else $error("Summary without header carries a checksum or entries.");

endmodule

bind rich_header_extract_checksum rhec_port_checks u_rhec_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
